// File: design/fold_boundary_hash_table_insert_unit_assert.svh
// Assertion macros for the fold-boundary hash table insert unit
`ifndef FOLD_BOUNDARY_HASH_TABLE_INSERT_UNIT_ASSERT_SVH
`define FOLD_BOUNDARY_HASH_TABLE_INSERT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FBH_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fbh assertion failed");

// Next-cycle implication, checked outside reset
`define FBH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fbh assertion failed");

`endif

// File: design/fbh_pkg.sv
// Shared constants and helpers for the fold-boundary hash table insert unit
`timescale 1ns / 1ps
package fbh_pkg;

  localparam int KEY_W  = 31;
  localparam int WORD_W = KEY_W + 1;
  localparam int CFG_W  = 11;
  localparam int FILL_W = 11;
  localparam int SLOT_W = 10;
  localparam int STAT_W = 2;
  localparam int DIG_W  = 4;
  localparam int P10_W  = 17;

  // floor(v / 10) == (v * RECIP10) >> 35 for any 32-bit v
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [STAT_W-1:0] ST_STORED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  function automatic logic [P10_W-1:0] pow10(input logic [2:0] e);
    logic [P10_W-1:0] r;
    unique case (e)
      3'd0:    r = 17'd1;
      3'd1:    r = 17'd10;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd1000;
      3'd4:    r = 17'd10000;
      3'd5:    r = 17'd100000;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/fold_boundary_hash_table_insert_unit.sv
// Top level: insert sequencer, slot memory and folding hash unit
// Inserts one key per request into an open-addressed table with linear probing.
// After reset a clearing pass writes every slot, with no request taken. A
// request then makes one sweep of the single slot memory port over the n slots
// of the table size in effect for the duplicate check, the shared divide-by-ten
// and accumulate unit stepping twice over the key's decimal digits, and a probe
// walk that reads one slot a cycle from the home slot. A full table skips the
// scan and goes straight to the result. The result waits in an output register.
`timescale 1ns / 1ps
module fold_boundary_hash_table_insert_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fbh_pkg::CFG_W-1:0]   cfg_table_size_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fbh_pkg::KEY_W-1:0]   insert_key_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [fbh_pkg::STAT_W-1:0]  status_o,
  output logic [fbh_pkg::SLOT_W-1:0]  home_slot_o,
  output logic [fbh_pkg::SLOT_W-1:0]  stored_slot_o
);
  import fbh_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SZW = ($clog2(TABLE_DEPTH + 1) > CFG_W) ? $clog2(TABLE_DEPTH + 1) : CFG_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_HASH  = 6'b001000,
    S_PROBE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [SZW-1:0] size_q, n, cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d, pend_addr_q, pend_addr_d, pos_q, pos_d, home_q, home_d;
  logic pend_q, pend_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [STAT_W-1:0] res_status_q, res_status_d, out_status_q;
  logic [SLOT_W-1:0] res_home_q, res_home_d, res_slot_q, res_slot_d;
  logic [SLOT_W-1:0] out_home_q, out_slot_q;
  logic out_valid_q, out_valid_d, out_load;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, rd_word;
  logic fold_start, fold_done;
  logic [SZW-1:0] fold_hash;
  logic [SZW-1:0] pos_inc;

  fbh_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rd_word)
  );

  fbh_fold #(.SZW(SZW)) u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fold_start),
    .key_i   (key_q),
    .size_i  (n),
    .done_o  (fold_done),
    .hash_o  (fold_hash)
  );

  // clamp the configured size to 1..TABLE_DEPTH
  always_comb begin
    if (size_q == '0) begin
      n = SZW'(1);
    end else if (size_q > SZW'(TABLE_DEPTH)) begin
      n = SZW'(TABLE_DEPTH);
    end else begin
      n = size_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign pos_inc     = SZW'(pos_q) + SZW'(1);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    pos_d        = pos_q;
    home_d       = home_q;
    key_d        = key_q;
    fill_d       = fill_q;
    res_status_d = res_status_q;
    res_home_d   = res_home_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = pend_addr_q;
    mem_wdata    = {1'b1, key_q};
    mem_raddr    = cnt_q[AW-1:0];
    fold_start   = 1'b0;
    out_load     = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          key_d      = insert_key_i;
          cnt_d      = '0;
          pend_d     = 1'b0;
          res_home_d = '0;
          res_slot_d = '0;
          if (SZW'(fill_q) >= n) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      // read slots 0..n-1, compare each in the following cycle
      S_SCAN: begin
        pend_d = 1'b0;
        if (pend_q && rd_word[WORD_W-1] && (rd_word[KEY_W-1:0] == key_q)) begin
          res_status_d = ST_DUP;
          state_d      = S_DONE;
        end else if (cnt_q < n) begin
          pend_d = 1'b1;
          cnt_d  = cnt_q + SZW'(1);
        end else if (!pend_q) begin
          fold_start = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (fold_done) begin
          pos_d   = AW'(fold_hash);
          home_d  = AW'(fold_hash);
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = S_PROBE;
        end
      end
      // walk upward from home, wrap at n, take the first free slot
      S_PROBE: begin
        pend_d    = 1'b0;
        mem_raddr = pos_q;
        if (pend_q && !rd_word[WORD_W-1]) begin
          mem_we       = 1'b1;
          fill_d       = fill_q + FILL_W'(1);
          res_status_d = ST_STORED;
          res_home_d   = SLOT_W'(home_q);
          res_slot_d   = SLOT_W'(pend_addr_q);
          state_d      = S_DONE;
        end else if (cnt_q < n) begin
          pend_d      = 1'b1;
          pend_addr_d = pos_q;
          cnt_d       = cnt_q + SZW'(1);
          pos_d       = (pos_inc >= n) ? '0 : AW'(pos_inc);
        end else if (!pend_q) begin
          res_status_d = ST_FULL;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      fill_q      <= '0;
      size_q      <= SZW'(TABLE_DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        size_q <= SZW'(cfg_table_size_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    pend_addr_q  <= pend_addr_d;
    pos_q        <= pos_d;
    home_q       <= home_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_home_q   <= res_home_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_home_q   <= res_home_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign home_slot_o   = out_home_q;
  assign stored_slot_o = out_slot_q;

`include "fold_boundary_hash_table_insert_unit_assert.svh"

  `FBH_ASSERT_NEXT(a_accept_moves_on, in_valid_i && !in_stall_o,
                   state_q == S_SCAN || state_q == S_DONE)
  `FBH_ASSERT_IMPL(a_clear_quiet, state_q == S_CLEAR, !out_valid_o && in_stall_o)
  `FBH_ASSERT_IMPL(a_reject_zero_slots, out_valid_o && status_o != ST_STORED,
                   home_slot_o == '0 && stored_slot_o == '0)
  `FBH_ASSERT_NEXT(a_store_counts, state_q == S_PROBE && pend_q && !rd_word[WORD_W-1],
                   fill_q == $past(fill_q) + FILL_W'(1))

endmodule

// File: design/fbh_table.sv
// Slot memory: one write port and one registered read port
`timescale 1ns / 1ps
module fbh_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [fbh_pkg::WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [fbh_pkg::WORD_W-1:0] rdata_o
);
  import fbh_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fbh_fold.sv
// Iterative folding hash: serial decimal digits, group accumulate, modulo reduce
`timescale 1ns / 1ps
module fbh_fold #(
  parameter int SZW = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [fbh_pkg::KEY_W-1:0] key_i,
  input  logic [SZW-1:0]           size_i,
  output logic                     done_o,
  output logic [SZW-1:0]           hash_o
);
  import fbh_pkg::*;

  localparam int SUMW = 20;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_LEN  = 6'b000010,
    F_DIG  = 6'b000100,
    F_ACC  = 6'b001000,
    F_MODL = 6'b010000,
    F_MODN = 6'b100000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [KEY_W-1:0] v_q, v_d;
  logic [DIG_W-1:0] digit_q, digit_d;
  logic [2:0] gw_q, gw_d, jcnt_q, jcnt_d;
  logic [3:0] icnt_q, icnt_d, groups_q, groups_d;
  logic [SUMW-1:0] sum_q, sum_d;

  logic [62:0] prod;
  logic [KEY_W-1:0] quot, rem;
  logic [SZW-1:0] nm1;
  logic [2:0] gw_c, expo;
  logic last_j, rev;
  logic [SUMW-1:0] term, lim, size_ext;

  // decimal digits are split off through a reciprocal multiply
  assign prod = 63'(v_q) * 63'(RECIP10);
  assign quot = KEY_W'(prod[62:35]);
  assign rem  = v_q - ((quot << 3) + (quot << 1));

  assign nm1 = size_i - SZW'(1);
  always_comb begin
    if (32'(nm1) < 32'd10) begin
      gw_c = 3'd1;
    end else if (32'(nm1) < 32'd100) begin
      gw_c = 3'd2;
    end else if (32'(nm1) < 32'd1000) begin
      gw_c = 3'd3;
    end else if (32'(nm1) < 32'd10000) begin
      gw_c = 3'd4;
    end else begin
      gw_c = 3'd5;
    end
  end

  assign last_j   = (jcnt_q == gw_q - 3'd1);
  assign rev      = (icnt_q == 4'd0) || (icnt_q == groups_q - 4'd1);
  assign expo     = rev ? (gw_q - 3'd1 - jcnt_q) : jcnt_q;
  assign term     = SUMW'(digit_q) * SUMW'(pow10(expo));
  assign lim      = SUMW'(pow10(gw_q));
  assign size_ext = SUMW'(size_i);

  always_comb begin
    state_d  = state_q;
    v_d      = v_q;
    digit_d  = digit_q;
    gw_d     = gw_q;
    jcnt_d   = jcnt_q;
    icnt_d   = icnt_q;
    groups_d = groups_q;
    sum_d    = sum_q;
    done_o   = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          v_d     = key_i;
          gw_d    = gw_c;
          jcnt_d  = '0;
          icnt_d  = '0;
          sum_d   = '0;
          state_d = F_LEN;
        end
      end
      // count digits and groups
      F_LEN: begin
        v_d = quot;
        if (quot == '0) begin
          groups_d = icnt_q + 4'd1;
          v_d      = key_i;
          jcnt_d   = '0;
          icnt_d   = '0;
          state_d  = F_DIG;
        end else if (last_j) begin
          jcnt_d = '0;
          icnt_d = icnt_q + 4'd1;
        end else begin
          jcnt_d = jcnt_q + 3'd1;
        end
      end
      F_DIG: begin
        digit_d = rem[DIG_W-1:0];
        v_d     = quot;
        state_d = F_ACC;
      end
      F_ACC: begin
        sum_d = sum_q + term;
        if (last_j && (icnt_q == groups_q - 4'd1)) begin
          state_d = F_MODL;
        end else begin
          state_d = F_DIG;
          if (last_j) begin
            jcnt_d = '0;
            icnt_d = icnt_q + 4'd1;
          end else begin
            jcnt_d = jcnt_q + 3'd1;
          end
        end
      end
      F_MODL: begin
        if (sum_q >= lim) begin
          sum_d = sum_q - lim;
        end else begin
          state_d = F_MODN;
        end
      end
      F_MODN: begin
        if (sum_q >= size_ext) begin
          sum_d = sum_q - size_ext;
        end else begin
          done_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign hash_o = SZW'(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    digit_q  <= digit_d;
    gw_q     <= gw_d;
    jcnt_q   <= jcnt_d;
    icnt_q   <= icnt_d;
    groups_q <= groups_d;
    sum_q    <= sum_d;
  end

endmodule

// File: test/fbh_insert_checker.sv
// Checker for the hash table insert unit: predicts each insert and compares results
`timescale 1ns / 1ps
module fbh_insert_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [fbh_pkg::CFG_W-1:0]   cfg_table_size_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [fbh_pkg::KEY_W-1:0]   insert_key_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [fbh_pkg::STAT_W-1:0]  status_i,
  input  logic [fbh_pkg::SLOT_W-1:0]  home_slot_i,
  input  logic [fbh_pkg::SLOT_W-1:0]  stored_slot_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 stored_cnt_o,
  output int unsigned                 dup_cnt_o,
  output int unsigned                 full_cnt_o
);
  import fbh_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] home;
    logic [SLOT_W-1:0] stored;
  } insert_result_t;

  logic [CFG_W-1:0] size_reg;
  logic [KEY_W-1:0] slot_key [DEPTH];
  logic             slot_used [DEPTH];
  logic [FILL_W-1:0] fill;
  insert_result_t   pending_q [$];

  assign pending_o = pending_q.size();

  function automatic int unsigned active_size(input logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > DEPTH) return DEPTH;
    return s;
  endfunction

  function automatic int unsigned fold_home(input logic [KEY_W-1:0] key,
                                            input int unsigned n);
    int unsigned dig [24];
    int unsigned len, gw, groups, pos;
    longint unsigned v, sum, g, p, lim, t;
    for (int k = 0; k < 24; k++) dig[k] = 0;
    v = key;
    len = 0;
    do begin
      dig[len] = int'(v % 10);
      v = v / 10;
      len++;
    end while (v != 0);
    t = n - 1;
    gw = 1;
    while (t >= 10) begin
      t = t / 10;
      gw++;
    end
    groups = (len + gw - 1) / gw;
    sum = 0;
    for (int unsigned i = 0; i < groups; i++) begin
      g = 0;
      p = 1;
      for (int unsigned j = 0; j < gw; j++) begin
        pos = i * gw + j;
        // outer groups read reversed, inner groups keep digit order
        if (i == 0 || i == groups - 1) g = g * 10 + dig[pos];
        else begin
          g = g + dig[pos] * p;
          p = p * 10;
        end
      end
      sum += g;
    end
    lim = 1;
    for (int unsigned j = 0; j < gw; j++) lim = lim * 10;
    if (sum >= lim) sum = sum % lim;
    if (sum >= n) sum = sum % n;
    return int'(sum);
  endfunction

  function automatic insert_result_t predict_insert(input logic [KEY_W-1:0] key);
    insert_result_t r;
    int unsigned n, home, slot;
    n = active_size(size_reg);
    r.status = ST_FULL;
    r.home = '0;
    r.stored = '0;
    if (fill >= n) return r;
    for (int unsigned i = 0; i < n; i++) begin
      if (slot_used[i] && slot_key[i] == key) begin
        r.status = ST_DUP;
        return r;
      end
    end
    home = fold_home(key, n);
    slot = home;
    for (int unsigned i = 0; i < n; i++) begin
      if (!slot_used[slot]) begin
        slot_used[slot] = 1'b1;
        slot_key[slot] = key;
        fill = fill + 1'b1;
        r.status = ST_STORED;
        r.home = SLOT_W'(home);
        r.stored = SLOT_W'(slot);
        return r;
      end
      slot++;
      if (slot >= n) slot = 0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    insert_result_t exp_r;
    if (!rst_ni) begin
      size_reg = CFG_W'(DEPTH);
      fill = '0;
      for (int k = 0; k < DEPTH; k++) begin
        slot_used[k] = 1'b0;
        slot_key[k] = '0;
      end
      pending_q.delete();
      errors_o = 0;
      stored_cnt_o = 0;
      dup_cnt_o = 0;
      full_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) size_reg = cfg_table_size_i;
      if (in_valid_i && !in_stall_i) pending_q.push_back(predict_insert(insert_key_i));
      if (out_valid_i && !out_stall_i) begin
        case (status_i)
          ST_STORED: stored_cnt_o++;
          ST_DUP:    dup_cnt_o++;
          default:   full_cnt_o++;
        endcase
        if (pending_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result with nothing pending: status %0d home %0d slot %0d",
                     $time, status_i, home_slot_i, stored_slot_i);
        end else begin
          exp_r = pending_q.pop_front();
          if (exp_r.status !== status_i || exp_r.home !== home_slot_i ||
              exp_r.stored !== stored_slot_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch: expected status %0d home %0d slot %0d, got %0d %0d %0d",
                       $time, exp_r.status, exp_r.home, exp_r.stored,
                       status_i, home_slot_i, stored_slot_i);
          end
        end
      end
    end
  end

endmodule

// File: test/tb.sv
// Testbench top: drives inserts and table size writes, reports the verdict
`timescale 1ns / 1ps
module tb;
  import fbh_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_size;
  logic               in_valid;
  logic               in_stall;
  logic [KEY_W-1:0]   in_key;
  logic               out_valid;
  logic               out_stall;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  home_slot;
  logic [SLOT_W-1:0]  stored_slot;

  int unsigned errors, pending, n_stored, n_dup, n_full;
  int unsigned keys_sent;
  int unsigned cycles;
  bit          quiet;
  bit          hold_req;
  logic [KEY_W-1:0] used_keys [$];

  fold_boundary_hash_table_insert_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_table_size_i(cfg_size),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .insert_key_i(in_key),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .home_slot_o(home_slot), .stored_slot_o(stored_slot)
  );

  fbh_insert_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_table_size_i(cfg_size),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .insert_key_i(in_key),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .home_slot_i(home_slot), .stored_slot_i(stored_slot),
    .errors_o(errors), .pending_o(pending),
    .stored_cnt_o(n_stored), .dup_cnt_o(n_dup), .full_cnt_o(n_full)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    bit          v;
    int unsigned len;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        v = 1'b1;
        len = 400;
        hold_req = 1'b0;
      end else if (quiet) begin
        v = 1'b0;
        len = 1;
      end else begin
        v = ($urandom_range(0, 2) == 0);
        len = $urandom_range(1, 8);
      end
      out_stall <= v;
      repeat (len) @(posedge clk_i);
    end
  end

  task automatic push_key(input logic [KEY_W-1:0] k);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_key <= k;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    used_keys.push_back(k);
    keys_sent++;
  endtask

  task automatic write_size(input logic [CFG_W-1:0] s);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_size <= s;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 999);
      2: return used_keys.size() ? used_keys[$urandom_range(0, used_keys.size() - 1)]
                                 : $urandom;
      3: return $urandom_range(0, 99999);
      default: return $urandom_range(0, 9999999);
    endcase
  endfunction

  task automatic random_keys(input int unsigned count);
    repeat (count) push_key(pick_key());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_size = '0;
    in_valid = 1'b0;
    in_key = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    keys_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // size zero acts as one: one store, then full even for a duplicate
    write_size(11'd0);
    push_key(31'd5);
    push_key(31'd5);
    push_key(31'd6);
    write_size(11'd1);
    push_key(31'd0);
    write_size(11'd10);
    push_key(31'd5);
    push_key(31'd0);
    push_key(31'h7FFF_FFFF);
    push_key(31'd9);
    push_key(31'd10);
    push_key(31'h5555_5555);
    push_key(31'h2AAA_AAAA);
    push_key(31'd19);
    push_key(31'd29);
    push_key(31'd39);
    push_key(31'd49);
    push_key(31'd59);
    random_keys(4);

    write_size(11'd37);
    random_keys(40);

    write_size(11'd100);
    push_key(31'd1000000000);
    push_key(31'd987654321);
    push_key(31'd12345);
    push_key(31'h7FFF_FFFF);
    hold_req = 1'b1;
    random_keys(90);

    write_size(11'd101);
    random_keys(30);

    write_size(11'd1024);
    random_keys(60);

    // oversize write clamps to the full depth; no idling from here on
    write_size(11'd2047);
    quiet = 1'b1;
    random_keys(20);
    in_valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d inserts over table sizes 0 to 2047 in %0d cycles", keys_sent, cycles);
    $display("results: %0d stored, %0d duplicate, %0d full", n_stored, n_dup, n_full);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
